// File: hw/rtl/ljcf_pkg.sv
// Shared types, constants and codes for the Lennard-Jones cutoff force block.
// Depends on nothing; every other file but the checker uses it by scoped names.
`timescale 1ns / 1ps
package ljcf_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    // saturation caps of the intermediate quantities
    localparam logic [63:0] ICAP = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QCAP = 64'h0000_0100_0000_0000;

    // floor(q / 10) = (q * RECIP_TEN) >> TEN_SHIFT, exact for q below 2^66
    localparam logic [63:0] RECIP_TEN = 64'hCCCC_CCCC_CCCC_CCCD;
    localparam int          TEN_SHIFT = 67;

    // last pass count of the shared multiplier
    localparam logic [2:0] MUL_LAST_CNT = 3'd4;

    // divider step counts and numerator alignment (MSB of numerator at bit 127)
    localparam int U_STEPS   = 62 + FRAC_BITS;
    localparam int FD_STEPS  = 97 + FRAC_BITS;
    localparam int U_ALIGN   = 128 - U_STEPS;
    localparam int FD_ALIGN  = 128 - FD_STEPS;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd5;

    // request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // request to the shared divider
    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [63:0]  den;
        logic [63:0]  cap;
        logic [6:0]   steps;
    } div_req_t;

endpackage

// File: hw/rtl/lennard_jones_cutoff_force.sv
// Top level: sequencer, config registers and result register of the LJ force block.
// Depends on ljcf_pkg, ljcf_mul and ljcf_div.
//
//   channel  direction  handshake           payload
//   cfg      in         cfg_wr_en           cfg_index, cfg_wdata
//   s        in         s_valid / s_ready   vertex x/y/z, image x/y, last_vertex
//   m        out        m_valid / m_ready   vertex force x/y/z, within_cutoff, sums, pass_done
//
// A vertex outside the cutoff box goes from the check straight to the result; one inside
// the box but outside the sphere, or coincident, takes four multiplies (rc^2, three squares).
// One in range takes 13 multiplies at Q16.16 plus one divide of U_STEPS quotient bits
// and three of FD_STEPS quotient bits.
// Reset is synchronous, active low; it clears the sums and restores the config.
// s_ready is high only while no vertex is in work; a finished result waits in
// the output register while the next vertex is accepted, and a result still
// waiting there stalls the sequencer in its last state.
`timescale 1ns / 1ps
module lennard_jones_cutoff_force (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ljcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [31:0]             s_vertex_x,
    input  logic signed [31:0]             s_vertex_y,
    input  logic signed [31:0]             s_vertex_z,
    input  logic signed [7:0]              s_image_x,
    input  logic signed [7:0]              s_image_y,
    input  logic                           s_last_vertex,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [31:0]             m_vertex_force_x,
    output logic signed [31:0]             m_vertex_force_y,
    output logic signed [31:0]             m_vertex_force_z,
    output logic                           m_within_cutoff,
    output logic signed [31:0]             m_particle_sum_x,
    output logic signed [31:0]             m_particle_sum_y,
    output logic signed [31:0]             m_particle_sum_z,
    output logic                           m_pass_done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UNWRAP = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_ISSUE  = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_EVAL   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        OP_RC2, OP_SQ, OP_U, OP_UU, OP_UUU, OP_P, OP_FM, OP_FD, OP_F10
    } op_t;

    // min(ICAP, prod >> FRAC_BITS)
    function automatic logic [63:0] mulq(input logic [127:0] p);
        mulq = ((p >> (62 + ljcf_pkg::FRAC_BITS)) != 128'd0) ? ljcf_pkg::ICAP :
               64'(p[61+ljcf_pkg::FRAC_BITS:ljcf_pkg::FRAC_BITS]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        if (x > 40'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
        else if (x < -40'sd2147483648) sat32 = 32'sh8000_0000;
        else                           sat32 = x[31:0];
    endfunction

    state_t state_reg;
    op_t    op_reg;

    // configuration
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [30:0]        box_x_reg, box_y_reg, rc_reg;

    // captured vertex
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic signed [7:0]  ix_reg, iy_reg;
    logic               last_reg;

    // working values
    logic signed [41:0] a_reg [3];
    logic [30:0]        abs_reg [3];
    logic               neg_reg [3];
    logic signed [39:0] f_reg [3];
    logic [1:0]         axis_reg;
    logic               inside_reg;
    logic [63:0]        rc2_reg, aa_reg, u_reg, w_reg, q_reg;
    logic [127:0]       fprod_reg;

    // sums and result register
    logic signed [31:0] sum_reg [3];
    logic signed [31:0] out_vf_reg [3];
    logic signed [31:0] out_sum_reg [3];
    logic               out_in_reg, out_last_reg, m_valid_reg;

    // units
    ljcf_pkg::mul_req_t mul_req;
    ljcf_pkg::div_req_t div_req;
    logic               mul_done, div_done, unit_done, is_div;
    logic [127:0]       mul_prod;
    logic [63:0]        div_quo;

    logic signed [39:0] off_x, off_y;
    logic signed [41:0] abs_full [3];
    logic               far;
    logic [34:0]        abs12;
    logic signed [39:0] m_s, f_new;
    logic signed [31:0] react [3];
    logic signed [31:0] sum_new [3];
    logic               out_free;

    ljcf_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req),
                    .done(mul_done), .prod(mul_prod));
    ljcf_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req),
                    .done(div_done), .quo(div_quo));

    // unwrap and range check
    always_comb begin
        off_x = 40'(ix_reg) * 40'($signed({1'b0, box_x_reg}));
        off_y = 40'(iy_reg) * 40'($signed({1'b0, box_y_reg}));
        far   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            abs_full[k] = a_reg[k][41] ? -a_reg[k] : a_reg[k];
            if (abs_full[k] > $signed({11'd0, rc_reg})) far = 1'b1;
        end
    end

    // operand selection for the shared units
    always_comb begin
        abs12   = {1'b0, abs_reg[axis_reg], 3'b000} + {2'b00, abs_reg[axis_reg], 2'b00};
        is_div  = (op_reg == OP_U) || (op_reg == OP_FD);
        mul_req = '0;
        div_req = '0;
        mul_req.start = (state_reg == S_ISSUE) && !is_div;
        div_req.start = (state_reg == S_ISSUE) && is_div;
        unique case (op_reg)
            OP_RC2: begin
                mul_req.a = 64'(rc_reg);
                mul_req.b = 64'(rc_reg);
            end
            OP_SQ: begin
                mul_req.a = 64'(abs_reg[axis_reg]);
                mul_req.b = 64'(abs_reg[axis_reg]);
            end
            OP_U: begin
                div_req.num   = (128'(rc2_reg) << ljcf_pkg::FRAC_BITS) << ljcf_pkg::U_ALIGN;
                div_req.den   = aa_reg;
                div_req.cap   = ljcf_pkg::ICAP;
                div_req.steps = 7'(ljcf_pkg::U_STEPS);
            end
            OP_UU: begin
                mul_req.a = u_reg;
                mul_req.b = u_reg;
            end
            OP_UUU: begin
                mul_req.a = w_reg;
                mul_req.b = u_reg;
            end
            OP_P: begin
                mul_req.a = w_reg;
                mul_req.b = (w_reg > ljcf_pkg::ONE) ? (w_reg - ljcf_pkg::ONE) : 64'd0;
            end
            OP_FM: begin
                mul_req.a = w_reg;
                mul_req.b = 64'(abs12);
            end
            OP_FD: begin
                div_req.num   = (fprod_reg << ljcf_pkg::FRAC_BITS) << ljcf_pkg::FD_ALIGN;
                div_req.den   = aa_reg;
                div_req.cap   = ljcf_pkg::QCAP;
                div_req.steps = 7'(ljcf_pkg::FD_STEPS);
            end
            // divide by ten as a reciprocal multiply
            OP_F10: begin
                mul_req.a = q_reg;
                mul_req.b = ljcf_pkg::RECIP_TEN;
            end
            default: begin
                mul_req.a = 64'd0;
            end
        endcase
        unit_done = is_div ? div_done : mul_done;
        m_s       = $signed({2'b00,
                             mul_prod[ljcf_pkg::TEN_SHIFT+37:ljcf_pkg::TEN_SHIFT]});
        f_new     = neg_reg[axis_reg] ? -m_s : m_s;
    end

    // reaction sums
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            react[k]   = sat32(f_reg[k]);
            sum_new[k] = sat32(40'(sum_reg[k]) + 40'(react[k]));
        end
        out_free = !m_valid_reg || m_ready;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg    <= 32'sd0;
            py_reg    <= 32'sd0;
            pz_reg    <= 32'sd0;
            box_x_reg <= 31'(ljcf_pkg::ONE);
            box_y_reg <= 31'(ljcf_pkg::ONE);
            rc_reg    <= 31'(ljcf_pkg::ONE);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ljcf_pkg::REG_PARTICLE_X: px_reg    <= cfg_wdata;
                ljcf_pkg::REG_PARTICLE_Y: py_reg    <= cfg_wdata;
                ljcf_pkg::REG_PARTICLE_Z: pz_reg    <= cfg_wdata;
                ljcf_pkg::REG_BOX_X:      box_x_reg <= cfg_wdata[30:0];
                ljcf_pkg::REG_BOX_Y:      box_y_reg <= cfg_wdata[30:0];
                ljcf_pkg::REG_CUTOFF:     rc_reg    <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) sum_reg[k] <= 32'sd0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:   if (s_valid) state_reg <= S_UNWRAP;
                S_UNWRAP: state_reg <= S_CHECK;
                S_CHECK:  state_reg <= far ? S_DONE : S_ISSUE;
                S_ISSUE:  state_reg <= S_WAIT;
                S_WAIT: begin
                    if (unit_done) begin
                        if (op_reg == OP_SQ && axis_reg == 2'd2) state_reg <= S_EVAL;
                        else if (op_reg == OP_F10 && axis_reg == 2'd2) state_reg <= S_DONE;
                        else state_reg <= S_ISSUE;
                    end
                end
                S_EVAL: begin
                    if (aa_reg > rc2_reg || aa_reg == 64'd0) state_reg <= S_DONE;
                    else state_reg <= S_ISSUE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        for (int k = 0; k < 3; k++)
                            sum_reg[k] <= last_reg ? 32'sd0 : sum_new[k];
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    vx_reg   <= s_vertex_x;
                    vy_reg   <= s_vertex_y;
                    vz_reg   <= s_vertex_z;
                    ix_reg   <= s_image_x;
                    iy_reg   <= s_image_y;
                    last_reg <= s_last_vertex;
                end
            end
            S_UNWRAP: begin
                a_reg[0] <= 42'(px_reg) - 42'(vx_reg) - 42'(off_x);
                a_reg[1] <= 42'(py_reg) - 42'(vy_reg) - 42'(off_y);
                a_reg[2] <= 42'(pz_reg) - 42'(vz_reg);
            end
            S_CHECK: begin
                for (int k = 0; k < 3; k++) begin
                    abs_reg[k] <= abs_full[k][30:0];
                    neg_reg[k] <= a_reg[k][41];
                    f_reg[k]   <= 40'sd0;
                end
                inside_reg <= !far;
                aa_reg     <= 64'd0;
                axis_reg   <= 2'd0;
                op_reg     <= OP_RC2;
            end
            S_WAIT: begin
                if (unit_done) begin
                    unique case (op_reg)
                        OP_RC2: begin
                            rc2_reg <= mul_prod[63:0];
                            op_reg  <= OP_SQ;
                        end
                        OP_SQ: begin
                            aa_reg   <= aa_reg + mul_prod[63:0];
                            axis_reg <= axis_reg + 2'd1;
                        end
                        OP_U: begin
                            u_reg  <= div_quo;
                            op_reg <= OP_UU;
                        end
                        OP_UU: begin
                            w_reg  <= mulq(mul_prod);
                            op_reg <= OP_UUU;
                        end
                        OP_UUU: begin
                            w_reg  <= mulq(mul_prod);
                            op_reg <= OP_P;
                        end
                        OP_P: begin
                            w_reg    <= mulq(mul_prod);
                            axis_reg <= 2'd0;
                            op_reg   <= OP_FM;
                        end
                        OP_FM: begin
                            fprod_reg <= mul_prod;
                            op_reg    <= OP_FD;
                        end
                        OP_FD: begin
                            q_reg  <= div_quo;
                            op_reg <= OP_F10;
                        end
                        OP_F10: begin
                            f_reg[axis_reg] <= f_new;
                            axis_reg        <= axis_reg + 2'd1;
                            op_reg          <= OP_FM;
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL: begin
                if (aa_reg > rc2_reg) inside_reg <= 1'b0;
                op_reg <= OP_U;
            end
            S_DONE: begin
                if (out_free) begin
                    for (int k = 0; k < 3; k++) begin
                        out_vf_reg[k]  <= sat32(-f_reg[k]);
                        out_sum_reg[k] <= sum_new[k];
                    end
                    out_in_reg   <= inside_reg;
                    out_last_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_vertex_force_x = out_vf_reg[0];
    assign m_vertex_force_y = out_vf_reg[1];
    assign m_vertex_force_z = out_vf_reg[2];
    assign m_within_cutoff  = out_in_reg;
    assign m_particle_sum_x = out_sum_reg[0];
    assign m_particle_sum_y = out_sum_reg[1];
    assign m_particle_sum_z = out_sum_reg[2];
    assign m_pass_done      = out_last_reg;

endmodule

// File: hw/rtl/ljcf_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier over four passes.
// Depends on ljcf_pkg (mul_req_t).
`timescale 1ns / 1ps
module ljcf_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  ljcf_pkg::mul_req_t req,
    output logic               done,
    output logic [127:0]       prod
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg, sh_next;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  a_half, b_half;
    logic [127:0] pp_aligned;

    // pick the halves for this pass
    always_comb begin
        a_half  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp_next = 64'(a_half) * 64'(b_half);
        sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
    end

    // place the registered partial product
    always_comb begin
        unique case (sh_reg)
            2'd0:    pp_aligned = {64'd0, pp_reg};
            2'd1:    pp_aligned = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_aligned = {pp_reg, 64'd0};
            default: pp_aligned = 128'd0;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == ljcf_pkg::MUL_LAST_CNT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= 128'd0;
        end else if (busy_reg) begin
            if (cnt_reg != ljcf_pkg::MUL_LAST_CNT) begin
                pp_reg <= pp_next;
                sh_reg <= sh_next;
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_aligned;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: hw/rtl/ljcf_div.sv
// Shared bit-serial restoring divider, one quotient bit a cycle, with a cap.
// Depends on ljcf_pkg (div_req_t).
`timescale 1ns / 1ps
module ljcf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  ljcf_pkg::div_req_t req,
    output logic               done,
    output logic [63:0]        quo
);

    logic [127:0] num_reg;
    logic [63:0]  den_reg, cap_reg, r_reg, q_reg;
    logic         over_reg, busy_reg, done_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  r_shift, r_next, q_next;
    logic         take, over_next;

    // one restoring step
    always_comb begin
        r_shift   = {r_reg[62:0], num_reg[127]};
        take      = (r_shift >= den_reg);
        r_next    = take ? (r_shift - den_reg) : r_shift;
        q_next    = {q_reg[62:0], take};
        over_next = over_reg | q_reg[63] | (q_next > cap_reg);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            cap_reg  <= req.cap;
            r_reg    <= 64'd0;
            q_reg    <= 64'd0;
            over_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[126:0], 1'b0};
            r_reg    <= r_next;
            q_reg    <= q_next;
            over_reg <= over_next;
        end
    end

    assign done = done_reg;
    assign quo  = over_reg ? cap_reg : q_reg;

endmodule

// File: hw/rtl/ljcf_checker.sv
// Port-level assertions for the Lennard-Jones cutoff force block, bound to the top.
// Depends on lennard_jones_cutoff_force port names only.
`timescale 1ns / 1ps
module ljcf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_vertex_force_x,
    input logic signed [31:0] m_vertex_force_y,
    input logic signed [31:0] m_vertex_force_z,
    input logic               m_within_cutoff
);

    // one vertex in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a vertex is in work");

    // a waiting result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_force_x)
                                && $stable(m_within_cutoff))
        else $error("stalled result changed");

    // outside the cutoff the vertex sees no force
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_within_cutoff |-> m_vertex_force_x == 32'sd0
            && m_vertex_force_y == 32'sd0 && m_vertex_force_z == 32'sd0)
        else $error("nonzero force outside cutoff");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind lennard_jones_cutoff_force ljcf_checker u_ljcf_checker (.*);

// File: bench/lennard_jones_cutoff_force_tb.sv
// Self-checking bench for the Lennard-Jones cutoff force block: random and directed vertices,
// predicted results compared field by field. Depends on ljcf_pkg and lennard_jones_cutoff_force.
`timescale 1ns / 1ps
module lennard_jones_cutoff_force_tb;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     MAX_REPORTS = 10;

    typedef struct {
        logic signed [31:0] vx, vy, vz;
        logic signed [7:0]  ix, iy;
        logic               last;
    } vertex_t;

    typedef struct {
        logic signed [31:0] fx, fy, fz;
        logic               in_cut;
        logic signed [31:0] sx, sy, sz;
        logic               done;
    } force_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [ljcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_vertex_x = '0, s_vertex_y = '0, s_vertex_z = '0;
    logic signed [7:0] s_image_x = '0, s_image_y = '0;
    logic s_last_vertex = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_vertex_force_x, m_vertex_force_y, m_vertex_force_z;
    logic m_within_cutoff;
    logic signed [31:0] m_particle_sum_x, m_particle_sum_y, m_particle_sum_z;
    logic m_pass_done;

    lennard_jones_cutoff_force dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bench copy of the registers and running reaction sums
    longint part_pos [3];
    longint box_len [2];
    longint cut_r;
    longint react_sum [3];

    vertex_t vertex_q [$];
    force_t  force_q [$];
    vertex_t cur_vertex;
    int  errors = 0;
    bit  idle_on = 1'b1;
    longint cycles = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Q.F multiply, floor, capped
    function automatic logic [63:0] mul_fix(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> ljcf_pkg::FRAC_BITS;
        return (p > {64'd0, ljcf_pkg::ICAP}) ? ljcf_pkg::ICAP : p[63:0];
    endfunction

    // expected result for one vertex; advances the running sums
    function automatic force_t lj_force(vertex_t v);
        force_t r;
        longint disp [3];
        longint frc [3];
        logic [63:0] mag [3];
        logic [63:0] aa, rc2, u, cube, pw;
        logic [127:0] q;
        bit in_range;
        disp[0] = part_pos[0] - (longint'(v.vx) + longint'(v.ix) * box_len[0]);
        disp[1] = part_pos[1] - (longint'(v.vy) + longint'(v.iy) * box_len[1]);
        disp[2] = part_pos[2] - longint'(v.vz);
        in_range = 1'b1;
        for (int k = 0; k < 3; k++) begin
            mag[k] = disp[k] < 0 ? -disp[k] : disp[k];
            frc[k] = 0;
            if (mag[k] > cut_r) in_range = 1'b0;
        end
        if (in_range) begin
            rc2 = cut_r * cut_r;
            aa = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            if (aa > rc2) begin
                in_range = 1'b0;
            end else if (aa != 0) begin
                q = ({64'd0, rc2} << ljcf_pkg::FRAC_BITS) / {64'd0, aa};
                u = (q > {64'd0, ljcf_pkg::ICAP}) ? ljcf_pkg::ICAP : q[63:0];
                cube = mul_fix(mul_fix(u, u), u);
                pw = mul_fix(cube, cube > ljcf_pkg::ONE ? cube - ljcf_pkg::ONE : 64'd0);
                for (int k = 0; k < 3; k++) begin
                    q = (({64'd0, pw} * {64'd0, 64'd12 * mag[k]}) << ljcf_pkg::FRAC_BITS)
                        / {64'd0, aa};
                    if (q > {64'd0, ljcf_pkg::QCAP}) q = {64'd0, ljcf_pkg::QCAP};
                    q = q / 10;
                    frc[k] = disp[k] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
                end
            end
        end
        for (int k = 0; k < 3; k++)
            react_sum[k] = sat32(react_sum[k] + sat32(frc[k]));
        r.fx = 32'(sat32(-frc[0]));
        r.fy = 32'(sat32(-frc[1]));
        r.fz = 32'(sat32(-frc[2]));
        r.in_cut = in_range;
        r.sx = 32'(react_sum[0]);
        r.sy = 32'(react_sum[1]);
        r.sz = 32'(react_sum[2]);
        r.done = v.last;
        if (v.last)
            for (int k = 0; k < 3; k++) react_sum[k] = 0;
        return r;
    endfunction

    // driver: one vertex transaction at a time, random gaps between them
    int gap_cnt = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                force_q.push_back(lj_force(cur_vertex));
                gap_cnt = gap_len();
            end
            if (gap_cnt > 0) begin
                gap_cnt--;
                s_valid <= 1'b0;
            end else if (vertex_q.size() > 0) begin
                cur_vertex = vertex_q.pop_front();
                s_vertex_x <= cur_vertex.vx;
                s_vertex_y <= cur_vertex.vy;
                s_vertex_z <= cur_vertex.vz;
                s_image_x <= cur_vertex.ix;
                s_image_y <= cur_vertex.iy;
                s_last_vertex <= cur_vertex.last;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: random stalls on the result side, compare with oldest expectation
    int stall_cnt = 0;
    always @(posedge aclk) begin
        force_t e;
        if (aresetn && m_valid && m_ready) begin
            if (force_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) $display("unexpected result transaction");
            end else begin
                e = force_q.pop_front();
                if (e.fx !== m_vertex_force_x || e.fy !== m_vertex_force_y ||
                    e.fz !== m_vertex_force_z || e.in_cut !== m_within_cutoff ||
                    e.sx !== m_particle_sum_x || e.sy !== m_particle_sum_y ||
                    e.sz !== m_particle_sum_z || e.done !== m_pass_done) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch exp f=%0d %0d %0d in=%0b s=%0d %0d %0d d=%0b",
                                 e.fx, e.fy, e.fz, e.in_cut, e.sx, e.sy, e.sz, e.done);
                        $display("         got f=%0d %0d %0d in=%0b s=%0d %0d %0d d=%0b",
                                 m_vertex_force_x, m_vertex_force_y, m_vertex_force_z,
                                 m_within_cutoff, m_particle_sum_x, m_particle_sum_y,
                                 m_particle_sum_z, m_pass_done);
                    end
                end
            end
        end
        if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 1'b0;
        end else begin
            stall_cnt = gap_len();
            m_ready <= (stall_cnt == 0);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [ljcf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            ljcf_pkg::REG_PARTICLE_X: part_pos[0] = longint'(signed'(data));
            ljcf_pkg::REG_PARTICLE_Y: part_pos[1] = longint'(signed'(data));
            ljcf_pkg::REG_PARTICLE_Z: part_pos[2] = longint'(signed'(data));
            ljcf_pkg::REG_BOX_X:      box_len[0] = longint'(data[30:0]);
            ljcf_pkg::REG_BOX_Y:      box_len[1] = longint'(data[30:0]);
            ljcf_pkg::REG_CUTOFF:     cut_r = longint'(data[30:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] bx, logic [31:0] by, logic [31:0] rc);
        write_reg(ljcf_pkg::REG_PARTICLE_X, px);
        write_reg(ljcf_pkg::REG_PARTICLE_Y, py);
        write_reg(ljcf_pkg::REG_PARTICLE_Z, pz);
        write_reg(ljcf_pkg::REG_BOX_X, bx);
        write_reg(ljcf_pkg::REG_BOX_Y, by);
        write_reg(ljcf_pkg::REG_CUTOFF, rc);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every queued vertex is sent and every result is back
    task automatic drain();
        while (vertex_q.size() > 0 || s_valid || force_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // vertex at a given displacement from the particle, unwrapped through images
    task automatic add_at(longint dx, longint dy, longint dz, int ix, int iy, bit last);
        vertex_t v;
        longint wx, wy, wz;
        wx = part_pos[0] - dx - longint'(ix) * box_len[0];
        wy = part_pos[1] - dy - longint'(iy) * box_len[1];
        if (wx < -64'sd2147483648 || wx > 64'sd2147483647) begin
            ix = 0;
            wx = part_pos[0] - dx;
        end
        if (wy < -64'sd2147483648 || wy > 64'sd2147483647) begin
            iy = 0;
            wy = part_pos[1] - dy;
        end
        wz = part_pos[2] - dz;
        v.vx = wx[31:0];
        v.vy = wy[31:0];
        v.vz = wz[31:0];
        v.ix = ix[7:0];
        v.iy = iy[7:0];
        v.last = last;
        vertex_q.push_back(v);
    endtask

    function automatic longint rand_comp(longint lim);
        longint m;
        m = longint'($urandom_range(0, int'(lim)));
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // mostly well-formed vertices near the particle, some noise
    task automatic random_phase(int n);
        vertex_t v;
        longint lim;
        int r, ix, iy;
        bit last;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            last = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 4) == 0) begin
                ix = $urandom_range(0, 255) - 128;
                iy = $urandom_range(0, 255) - 128;
            end else begin
                ix = $urandom_range(0, 6) - 3;
                iy = $urandom_range(0, 6) - 3;
            end
            if (r < 20) begin
                v.vx = $urandom;
                v.vy = $urandom;
                v.vz = $urandom;
                v.ix = 8'($urandom);
                v.iy = 8'($urandom);
                v.last = last;
                vertex_q.push_back(v);
            end else begin
                lim = (r < 60) ? cut_r / 2 : (r < 75) ? cut_r / 64 : (r < 90) ? cut_r : cut_r + 2;
                add_at(rand_comp(lim), rand_comp(lim), rand_comp(lim), ix, iy, last);
            end
        end
        if ($urandom_range(0, 1)) add_at(0, 0, 0, 0, 0, 1'b1);
    endtask

    initial begin
        part_pos = '{0, 0, 0};
        box_len = '{65536, 65536};
        cut_r = 65536;
        react_sum = '{0, 0, 0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: field extremes and special cases
        add_at(0, 0, 0, 0, 0, 1'b0);                 // coincident points
        add_at(65536, 0, 0, 1, -1, 1'b0);            // on the cutoff along one axis
        add_at(65537, 0, 0, 0, 0, 1'b0);             // far component
        add_at(40000, 40000, 40000, 2, 3, 1'b0);     // components inside, sphere outside
        add_at(1, 0, 0, 0, 0, 1'b0);                 // extreme overlap
        add_at(-1, -1, -1, -128, 127, 1'b0);
        add_at(30000, -20000, 10000, 127, -128, 1'b0);
        add_at(-58000, 0, 0, 0, 0, 1'b1);            // last vertex
        begin
            vertex_t v;
            v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -8'sd128, 8'sd127, 1'b0};
            vertex_q.push_back(v);
            v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'sd127, -8'sd128, 1'b1};
            vertex_q.push_back(v);
        end
        drain();

        // zero cutoff, extreme particle and boxes; unused indexes too
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
        add_at(0, 0, 0, 5, -5, 1'b0);
        add_at(1, 0, 0, 0, 0, 1'b1);
        random_phase(20);
        drain();

        // largest cutoff and boxes
        idle_on = 1'b0;
        set_config(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_at(64'sd2147483647, 0, 0, 0, 0, 1'b0);
        add_at(1, 1, 1, 0, 0, 1'b0);
        random_phase(60);
        drain();
        idle_on = 1'b1;

        // tiny cutoff: huge forces, saturated sums
        set_config($urandom, $urandom, $urandom, 32'h0003_0000, 32'h0002_8000, 32'd256);
        for (int i = 0; i < 12; i++) add_at(rand_comp(8), rand_comp(8), rand_comp(8), 0, 0, 1'b0);
        random_phase(60);
        drain();

        // random settings, mostly moderate cutoffs
        for (int ph = 0; ph < 8; ph++) begin
            set_config($urandom, $urandom, $urandom, $urandom_range(0, 32'h00FF_FFFF),
                       $urandom_range(0, 32'h00FF_FFFF),
                       (ph == 7) ? $urandom : $urandom_range(1, 32'h0008_0000));
            idle_on = (ph != 3);
            random_phase(70);
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/ljcf_pkg.sv
hw/rtl/ljcf_mul.sv
hw/rtl/ljcf_div.sv
hw/rtl/lennard_jones_cutoff_force.sv
hw/rtl/ljcf_checker.sv
bench/lennard_jones_cutoff_force_tb.sv
